[design/wpo_pkg.sv]
// wpo_pkg: shared widths, register indexes, reset values and the
// controller/datapath command and status bundles of the peak overview block.
// No dependencies.
package wpo_pkg;

   localparam int DEF_SAMPLE_BITS  = 24;
   localparam int DEF_MAX_CHANNELS = 8;
   localparam int DEF_MAX_BINS     = 65536;

   localparam int CHCNT_W    = 4;    // channel_count register
   localparam int FRAME_W    = 25;   // frame_count register, frame counters
   localparam int BINCNT_W   = 17;   // bin_count register, bin counters
   localparam int BIN_NUM_W  = 16;   // bin_number field
   localparam int CSR_DATA_W = 25;
   localparam int CSR_IDX_W  = 2;
   localparam int RATIO_SHIFT = 5;   // bins may not exceed 32 x frames

   localparam logic [CHCNT_W-1:0]  RST_CHANNELS = CHCNT_W'(1);
   localparam logic [FRAME_W-1:0]  RST_FRAMES   = FRAME_W'(1);
   localparam logic [BINCNT_W-1:0] RST_BINS     = BINCNT_W'(1024);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CHANNELS = 2'd0,
      REG_FRAMES   = 2'd1,
      REG_BINS     = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic div_cfg_start;  // start frames / bins divide
      logic load_ratio;     // take quotient and remainder as bin step
      logic restart;        // clear stream state
      logic take;           // accumulate the accepted sample
      logic div_mag_start;  // start |frame sum| / channels divide
      logic emit;           // close the current bin
      logic update;         // fold mono magnitude into peak, count frame
      logic finish;         // push held result as last of the beat
      logic err_out;        // push a config error result
   } cmd_type;

   typedef struct packed {
      logic cfg_write;   // a known register is written this cycle
      logic frame_end;   // the sample on the input closes a frame
      logic bad_ratio;
      logic div_done;
      logic more;        // current bin ends at or before the frame index
      logic frame_open;  // frame index below frame count
      logic can_emit;
      logic held_valid;
      logic out_free;
      logic last_seen;   // the beat being worked on carried tlast
   } status_type;

endpackage

[design/wpo_div.sv]
// wpo_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; shared by the ratio setup and the channel average.
module wpo_div #(
   parameter int N = 27,  // dividend and quotient width
   parameter int D = 17   // divisor and remainder width
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient,
   output logic [D-1:0] remainder
);

   localparam int CNT_W = $clog2(N + 1);

   logic [N-1:0]     quo_ff, quo_in;
   logic [D-1:0]     rem_ff, rem_in;
   logic [D-1:0]     dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D:0]       rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[N-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[N-2:0], ge};
         rem_in = ge ? D'(rem_sh - {1'b0, dvs_ff}) : rem_sh[D-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[design/wpo_datapath.sv]
// wpo_datapath: config registers, frame accumulator, bin boundary stepper,
// running peak, held result and output register. Uses wpo_pkg and wpo_div.
module wpo_datapath
   import wpo_pkg::*;
#(
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_BINS     = DEF_MAX_BINS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          sample_last,
   input  cmd_type                       cmd,
   output status_type                    status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [SAMPLE_BITS-1:0]        out_peak,
   output logic [BIN_NUM_W-1:0]          out_bin,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);

   localparam int EC_W  = $clog2(MAX_CHANNELS + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_CHANNELS);
   localparam int DIV_N = (SUM_W > FRAME_W) ? SUM_W : FRAME_W;

   // config
   logic [CHCNT_W-1:0]  ch_ff, ch_in;
   logic [FRAME_W-1:0]  fr_ff, fr_in;
   logic [BINCNT_W-1:0] bn_ff, bn_in;
   logic [EC_W-1:0]     eff_c;
   logic [FRAME_W-1:0]  eff_f;
   logic [BINCNT_W-1:0] eff_b;

   // stream state
   logic [EC_W-1:0]         ci_ff, ci_in, ci_inc;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0]        abs_sum;
   logic [FRAME_W-1:0]      fidx_ff, fidx_in;
   logic [BINCNT_W-1:0]     bidx_ff, bidx_in;
   logic [FRAME_W-1:0]      bend_ff, bend_in;
   logic [BINCNT_W-1:0]     erem_ff, erem_in;
   logic [FRAME_W-1:0]      q_ff, q_in;
   logic [BINCNT_W-1:0]     r_ff, r_in;
   logic [SAMPLE_BITS-1:0]  peak_ff, peak_in;
   logic                    last_ff, last_in;
   logic [BINCNT_W:0]       erem_sum;
   logic                    wrap;

   // held result and output register
   logic                   hv_ff, hv_in;
   logic [SAMPLE_BITS-1:0] hpeak_ff, hpeak_in;
   logic [BIN_NUM_W-1:0]   hbin_ff, hbin_in;
   logic                   ov_ff, ov_in;
   logic                   load_out;
   logic [SAMPLE_BITS-1:0] opeak_ff, opeak_in;
   logic [BIN_NUM_W-1:0]   obin_ff, obin_in;
   logic                   olast_ff, olast_in;
   logic                   oerr_ff, oerr_in;

   // divider
   logic                div_start;
   logic [DIV_N-1:0]    div_dvd;
   logic [BINCNT_W-1:0] div_dvs;
   logic                div_done;
   logic [DIV_N-1:0]    div_q;
   logic [BINCNT_W-1:0] div_r;
   logic [SAMPLE_BITS-1:0] mag;

   always_comb begin
      if (ch_ff == '0)
         eff_c = EC_W'(1);
      else if (int'(ch_ff) > MAX_CHANNELS)
         eff_c = EC_W'(MAX_CHANNELS);
      else
         eff_c = EC_W'(ch_ff);
      eff_f = (fr_ff == '0) ? FRAME_W'(1) : fr_ff;
      if (bn_ff == '0)
         eff_b = BINCNT_W'(1);
      else if (int'(bn_ff) > MAX_BINS)
         eff_b = BINCNT_W'(MAX_BINS);
      else
         eff_b = bn_ff;
   end

   assign abs_sum   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_start = cmd.div_cfg_start | cmd.div_mag_start;
   assign div_dvd   = cmd.div_cfg_start ? DIV_N'(eff_f) : DIV_N'(abs_sum);
   assign div_dvs   = cmd.div_cfg_start ? eff_b : BINCNT_W'(eff_c);
   assign mag       = div_q[SAMPLE_BITS-1:0];

   wpo_div #(
      .N(DIV_N),
      .D(BINCNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign ci_inc   = ci_ff + EC_W'(1);
   assign erem_sum = {1'b0, erem_ff} + {1'b0, r_ff};
   assign wrap     = erem_sum >= {1'b0, eff_b};

   always_comb begin
      status.cfg_write  = csr_we && (csr_index == REG_CHANNELS ||
                                     csr_index == REG_FRAMES ||
                                     csr_index == REG_BINS);
      status.frame_end  = (ci_inc >= eff_c) || sample_last;
      status.bad_ratio  = {13'd0, eff_b} > {eff_f, RATIO_SHIFT'(0)};
      status.div_done   = div_done;
      status.more       = (bidx_ff < eff_b) && (bend_ff <= fidx_ff);
      status.frame_open = fidx_ff < eff_f;
      status.out_free   = !ov_ff || rsp_tready;
      status.can_emit   = !hv_ff || status.out_free;
      status.held_valid = hv_ff;
      status.last_seen  = last_ff;
   end

   always_comb begin
      ch_in = ch_ff;
      fr_in = fr_ff;
      bn_in = bn_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CHANNELS: ch_in = csr_data[CHCNT_W-1:0];
            REG_FRAMES:   fr_in = csr_data[FRAME_W-1:0];
            REG_BINS:     bn_in = csr_data[BINCNT_W-1:0];
            default: ;
         endcase
      end

      ci_in   = ci_ff;
      sum_in  = sum_ff;
      fidx_in = fidx_ff;
      bidx_in = bidx_ff;
      bend_in = bend_ff;
      erem_in = erem_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      peak_in = peak_ff;
      last_in = last_ff;
      hv_in    = hv_ff;
      hpeak_in = hpeak_ff;
      hbin_in  = hbin_ff;
      ov_in    = ov_ff && !rsp_tready;
      load_out = 1'b0;
      opeak_in = hpeak_ff;
      obin_in  = hbin_ff;
      olast_in = 1'b0;
      oerr_in  = 1'b0;

      if (cmd.restart) begin
         ci_in   = '0;
         sum_in  = '0;
         fidx_in = '0;
         bidx_in = '0;
         peak_in = '0;
         bend_in = q_ff;
         erem_in = r_ff;
      end
      if (cmd.load_ratio) begin
         q_in    = div_q[FRAME_W-1:0];
         r_in    = div_r;
         bend_in = div_q[FRAME_W-1:0];
         erem_in = div_r;
      end
      if (cmd.take) begin
         sum_in  = sum_ff + SUM_W'(sample);
         ci_in   = status.frame_end ? '0 : ci_inc;
         last_in = sample_last;
      end
      if (cmd.div_mag_start)
         sum_in = '0;
      if (cmd.update) begin
         if (mag > peak_ff)
            peak_in = mag;
         fidx_in = fidx_ff + FRAME_W'(1);
      end
      if (cmd.emit) begin
         // older held bin moves out, the closing bin takes its place
         if (hv_ff) begin
            ov_in    = 1'b1;
            load_out = 1'b1;
         end
         hv_in    = 1'b1;
         hpeak_in = peak_ff;
         hbin_in  = bidx_ff[BIN_NUM_W-1:0];
         peak_in  = '0;
         bidx_in  = bidx_ff + BINCNT_W'(1);
         bend_in  = bend_ff + q_ff + FRAME_W'(wrap);
         erem_in  = wrap ? BINCNT_W'(erem_sum - {1'b0, eff_b}) : erem_sum[BINCNT_W-1:0];
      end
      if (cmd.finish) begin
         hv_in    = 1'b0;
         ov_in    = 1'b1;
         load_out = 1'b1;
         olast_in = 1'b1;
      end
      if (cmd.err_out) begin
         ov_in    = 1'b1;
         load_out = 1'b1;
         opeak_in = '0;
         obin_in  = '0;
         olast_in = 1'b1;
         oerr_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff   <= RST_CHANNELS;
         fr_ff   <= RST_FRAMES;
         bn_ff   <= RST_BINS;
         ci_ff   <= '0;
         sum_ff  <= '0;
         fidx_ff <= '0;
         bidx_ff <= '0;
         bend_ff <= '0;
         erem_ff <= '0;
         q_ff    <= '0;
         r_ff    <= '0;
         peak_ff <= '0;
         last_ff <= 1'b0;
         hv_ff   <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         ch_ff   <= ch_in;
         fr_ff   <= fr_in;
         bn_ff   <= bn_in;
         ci_ff   <= ci_in;
         sum_ff  <= sum_in;
         fidx_ff <= fidx_in;
         bidx_ff <= bidx_in;
         bend_ff <= bend_in;
         erem_ff <= erem_in;
         q_ff    <= q_in;
         r_ff    <= r_in;
         peak_ff <= peak_in;
         last_ff <= last_in;
         hv_ff   <= hv_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      hpeak_ff <= hpeak_in;
      hbin_ff  <= hbin_in;
      if (load_out) begin
         opeak_ff <= opeak_in;
         obin_ff  <= obin_in;
         olast_ff <= olast_in;
         oerr_ff  <= oerr_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign out_peak   = opeak_ff;
   assign out_bin    = obin_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = oerr_ff;

endmodule

[design/wpo_ctrl.sv]
// wpo_ctrl: sequencer for setup, sample intake, channel divide and bin flush.
// Uses wpo_pkg; drives the datapath only through cmd_type.
module wpo_ctrl
   import wpo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_START,
      S_CFG,
      S_IDLE,
      S_ERR,
      S_MSTART,
      S_MDIV,
      S_FLUSH1,
      S_UPD,
      S_FLUSH2,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign accept = req_tvalid && ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_START: begin
            cmd.div_cfg_start = 1'b1;
            state_in          = S_CFG;
         end
         S_CFG: begin
            if (status.div_done) begin
               cmd.load_ratio = 1'b1;
               cmd.restart    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (status.bad_ratio) begin
                  state_in = S_ERR;
               end else begin
                  cmd.take = 1'b1;
                  if (status.frame_end)
                     state_in = S_MSTART;
               end
            end
         end
         S_ERR: begin
            if (status.out_free) begin
               cmd.err_out = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_MSTART: begin
            cmd.div_mag_start = 1'b1;
            state_in          = S_MDIV;
         end
         S_MDIV: begin
            if (status.div_done)
               state_in = status.frame_open ? S_FLUSH1 : S_FIN;
         end
         S_FLUSH1: begin
            if (!status.more)
               state_in = S_UPD;
            else if (status.can_emit)
               cmd.emit = 1'b1;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_FLUSH2;
         end
         S_FLUSH2: begin
            if (!status.more)
               state_in = S_FIN;
            else if (status.can_emit)
               cmd.emit = 1'b1;
         end
         S_FIN: begin
            if (!status.held_valid) begin
               cmd.restart = status.last_seen;
               state_in    = S_IDLE;
            end else if (status.out_free) begin
               cmd.finish  = 1'b1;
               cmd.restart = status.last_seen;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_START;
      endcase
      // any register write recomputes the bin step and restarts the stream
      if (status.cfg_write) begin
         cmd      = '0;
         state_in = S_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_START;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

[design/waveform_peak_overview.sv]
// waveform_peak_overview: top level of the peak envelope decimator.
// Depends on wpo_pkg, wpo_ctrl, wpo_datapath (which holds wpo_div).
//
// Usage
//   req_*  : one interleaved signed sample per beat; tlast marks the final
//            sample of the stream and closes a partial frame.
//   rsp_*  : one beat per closed bin: peak and bin number in tdata, tlast on
//            the last result caused by an input beat, tuser = config error.
//   csr_*  : write channel_count (0), frame_count (1), bin_count (2) while
//            idle. A write restarts the stream and recomputes the bin step.
// Flow
//   A sample that does not close a frame keeps req_tready high. A sample that
//   closes one holds it low while the divider (DIV_N = max(25, sample bits +
//   log2 channels) bits, 27 by default, one bit per cycle) forms the average
//   and each closed bin is emitted. Results stream out while the block works.
// Reset and stalls
//   After reset and after each register write the divider computes the bin
//   step (frames / bins) with req_tready low. If rsp_tready stays low, one
//   result sits in the output register, one more is held, and the block then
//   stops until the receiver takes a beat; nothing is lost.
//   With bins above 32 x frames every sample yields one error result.
module waveform_peak_overview
   import wpo_pkg::*;
#(
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_BINS     = DEF_MAX_BINS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // input sample stream
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         req_tdata,  // sample
   input  logic                                     req_tlast,  // last_sample
   // result stream
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((SAMPLE_BITS+BIN_NUM_W+7)/8)*8-1:0] rsp_tdata, // peak, bin_number
   output logic                                     rsp_tlast,  // run_last
   output logic                                     rsp_tuser,  // config_error
   // register writes
   input  logic                                     csr_we,
   input  logic [CSR_IDX_W-1:0]                     csr_index,
   input  logic [CSR_DATA_W-1:0]                    csr_data
);

   localparam int OUT_W = ((SAMPLE_BITS + BIN_NUM_W + 7) / 8) * 8;

   cmd_type                cmd;
   status_type             status;
   logic [SAMPLE_BITS-1:0] out_peak;
   logic [BIN_NUM_W-1:0]   out_bin;

   wpo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wpo_datapath #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_BINS     (MAX_BINS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .sample      (req_tdata[SAMPLE_BITS-1:0]),
      .sample_last (req_tlast),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_peak    (out_peak),
      .out_bin     (out_bin),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   // peak in the low bits, bin number above, zero fill to whole bytes
   assign rsp_tdata = OUT_W'({out_bin, out_peak});

endmodule

[design/wpo_checker.sv]
// wpo_checker: port-level assertions for waveform_peak_overview, and the
// bind that attaches them. Uses wpo_pkg.
module wpo_checker
   import wpo_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input logic                                       clock,
   input logic                                       reset,
   input logic                                       req_tready,
   input logic                                       rsp_tvalid,
   input logic                                       rsp_tready,
   input logic [((SAMPLE_BITS+BIN_NUM_W+7)/8)*8-1:0] rsp_tdata,
   input logic                                       rsp_tlast,
   input logic                                       rsp_tuser,
   input logic                                       csr_we,
   input logic [CSR_IDX_W-1:0]                       csr_index
);

   localparam int OUT_W = ((SAMPLE_BITS + BIN_NUM_W + 7) / 8) * 8;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // error result is a lone zero beat
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == OUT_W'(0))
      else $error("config error beat malformed");

   // magnitude never exceeds full scale
   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[SAMPLE_BITS-1:0] <= (SAMPLE_BITS'(1) << (SAMPLE_BITS - 1)))
      else $error("peak above full scale");

   // register write blocks intake while the bin step is recomputed
   a_cfg_block: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == REG_CHANNELS || csr_index == REG_FRAMES ||
                 csr_index == REG_BINS) |=> !req_tready)
      else $error("intake open right after register write");

   // no intake straight out of reset
   a_reset_block: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("intake open right after reset");

endmodule

bind waveform_peak_overview wpo_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_wpo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .csr_we     (csr_we),
   .csr_index  (csr_index)
);
